// ===== hdl/fdd_pkg.sv =====
// ----------------------------------------------------------------------------
// fdd_pkg
// Shared types and constants for the three-point finite-difference block.
// ----------------------------------------------------------------------------
package fdd_pkg;

    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF    = 16;

    // result and configuration widths are fixed
    localparam int OUT_W   = 32;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_INV_TWO_STEP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_SQ  = 1'b1;

    localparam logic [CFG_W-1:0] INV_TWO_STEP_RST = 32'h0000_8000;
    localparam logic [CFG_W-1:0] INV_STEP_SQ_RST  = 32'h0001_0000;

    localparam logic [OUT_W-1:0] POS_LIM = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] NEG_LIM = 32'h8000_0000;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        SEEN_NONE,
        SEEN_ONE,
        SEEN_TWO,
        SEEN_STEADY
    } t_seen;

    typedef enum logic [1:0] {
        K_SHORT,
        K_FIRST,
        K_MID,
        K_LAST
    } t_kind;

    // per-entry classification written by the front
    typedef struct packed {
        logic shrt;    // series ended before three samples
        logic seen3;   // window already steady, first point given earlier
        logic last;    // this sample ends the series
    } t_ent_flags;

    localparam int FLAG_W = $bits(t_ent_flags);

    typedef struct packed {
        logic has_second;
        logic series_end;
        logic last_of_run;
        logic short_series;
    } t_res_flags;

    typedef struct packed {
        logic valid;   // head entry present
        logic full;    // no room for another entry
    } t_q_status;

endpackage

// ===== hdl/finite_difference_derivatives_top.sv =====
// ----------------------------------------------------------------------------
// finite_difference_derivatives_top
// Three-point finite-difference first and second derivatives of a stream of
// equally spaced fixed-point samples.
//
//   channel   dir  handshake          payload
//   sample    in   i_valid / o_stall  i_sample, i_last_sample
//   result    out  o_valid / i_stall  o_first/second_derivative, flags
//   config    in   i_cfg_we           i_cfg_index, i_cfg_data
//
// One sample per cycle in a steady series while the queue has room; each sample
// gives zero to three result beats and the back end issues one beat per cycle
// unless stalled, so series ends cost an extra beat each. Registers from sample
// to result: queue write, numerator, magnitude, multiply, round, output register.
// Synchronous active-low reset empties the window and the four-entry queue. A
// stalled result freezes the back pipeline; the front fills the queue meanwhile.
// ----------------------------------------------------------------------------
module finite_difference_derivatives_top #(
    parameter int SAMPLE_WIDTH = fdd_pkg::SAMPLE_WIDTH_DEF,
    parameter int FRAC_BITS    = fdd_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fdd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fdd_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_sample,
    input  logic                            i_last_sample,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [fdd_pkg::OUT_W-1:0] o_first_derivative,
    output logic signed [fdd_pkg::OUT_W-1:0] o_second_derivative,
    output logic                            o_has_second,
    output logic                            o_series_end,
    output logic                            o_last_of_run,
    output logic                            o_short_series
);

    localparam int EW = 3 * SAMPLE_WIDTH + fdd_pkg::FLAG_W;

    logic                 push, pop;
    logic [EW-1:0]        entry_in, entry_head;
    fdd_pkg::t_q_status   q_status;
    fdd_pkg::t_res_flags  res_flags;
    logic [fdd_pkg::OUT_W-1:0] d1, d2;

    fdd_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .EW           (EW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_sample      (i_sample),
        .i_last_sample (i_last_sample),
        .o_stall       (o_stall),
        .i_q_status    (q_status),
        .o_push        (push),
        .o_entry       (entry_in)
    );

    fdd_queue #(
        .WIDTH (EW)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (entry_in),
        .i_pop    (pop),
        .o_data   (entry_head),
        .o_status (q_status)
    );

    fdd_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FRAC_BITS    (FRAC_BITS),
        .EW           (EW)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_q_status          (q_status),
        .i_entry             (entry_head),
        .o_pop               (pop),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_first_derivative  (d1),
        .o_second_derivative (d2),
        .o_flags             (res_flags)
    );

    assign o_first_derivative  = $signed(d1);
    assign o_second_derivative = $signed(d2);
    assign o_has_second        = res_flags.has_second;
    assign o_series_end        = res_flags.series_end;
    assign o_last_of_run       = res_flags.last_of_run;
    assign o_short_series      = res_flags.short_series;

endmodule

// ===== hdl/fdd_queue.sv =====
// ----------------------------------------------------------------------------
// fdd_queue
// Small FIFO that holds classified entries between front and back.
// ----------------------------------------------------------------------------
module fdd_queue #(
    parameter int WIDTH = 99
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output fdd_pkg::t_q_status o_status
);

    logic [WIDTH-1:0]               r_mem [fdd_pkg::QDEPTH];
    logic [fdd_pkg::QPTR_W-1:0]     r_wptr, n_wptr;
    logic [fdd_pkg::QPTR_W-1:0]     r_rptr, n_rptr;
    logic [fdd_pkg::QCNT_W-1:0]     r_count, n_count;

    always_comb begin
        n_wptr  = i_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = i_pop  ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data          = r_mem[r_rptr];
    assign o_status.valid  = (r_count != '0);
    assign o_status.full   = (r_count == fdd_pkg::QCNT_W'(fdd_pkg::QDEPTH));

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.full && !i_pop |=> r_count == fdd_pkg::QCNT_W'(fdd_pkg::QDEPTH))
        else $error("queue count moved past depth");
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 |-> r_wptr == r_rptr)
        else $error("empty queue with pointers apart");
`endif

endmodule

// ===== hdl/fdd_front.sv =====
// ----------------------------------------------------------------------------
// fdd_front
// Accepts samples, keeps the two-sample window and pushes one entry for
// every sample that causes results.
// ----------------------------------------------------------------------------
module fdd_front #(
    parameter int SAMPLE_WIDTH = fdd_pkg::SAMPLE_WIDTH_DEF,
    parameter int EW           = 3 * SAMPLE_WIDTH + fdd_pkg::FLAG_W
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                           i_last_sample,
    output logic                           o_stall,
    input  fdd_pkg::t_q_status             i_q_status,
    output logic                           o_push,
    output logic [EW-1:0]                  o_entry
);

    fdd_pkg::t_seen           r_state, n_state;
    logic [SAMPLE_WIDTH-1:0]  r_older, n_older;
    logic [SAMPLE_WIDTH-1:0]  r_newer, n_newer;
    fdd_pkg::t_ent_flags      flags;
    logic                     accept;

    assign o_stall = i_q_status.full;
    assign accept  = i_valid && !i_q_status.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fdd_pkg::SEEN_NONE;
            r_older <= '0;
            r_newer <= '0;
        end else begin
            r_state <= n_state;
            r_older <= n_older;
            r_newer <= n_newer;
        end
    end

    always_comb begin
        n_state = r_state;
        n_older = r_older;
        n_newer = r_newer;
        o_push  = 1'b0;
        flags   = '0;
        if (accept) begin
            flags.last = i_last_sample;
            unique case (r_state) inside
                fdd_pkg::SEEN_NONE, fdd_pkg::SEEN_ONE: begin
                    if (i_last_sample) begin
                        o_push     = 1'b1;
                        flags.shrt = 1'b1;
                    end else begin
                        n_older = r_newer;
                        n_newer = i_sample;
                        n_state = (r_state == fdd_pkg::SEEN_NONE) ?
                                  fdd_pkg::SEEN_ONE : fdd_pkg::SEEN_TWO;
                    end
                end
                fdd_pkg::SEEN_TWO, fdd_pkg::SEEN_STEADY: begin
                    o_push      = 1'b1;
                    flags.seen3 = (r_state == fdd_pkg::SEEN_STEADY);
                    n_older     = r_newer;
                    n_newer     = i_sample;
                    n_state     = fdd_pkg::SEEN_STEADY;
                end
                default: begin
                    n_state = fdd_pkg::SEEN_NONE;
                end
            endcase
            // end of series: window back to empty
            if (i_last_sample) begin
                n_older = '0;
                n_newer = '0;
                n_state = fdd_pkg::SEEN_NONE;
            end
        end
    end

    assign o_entry = {flags, r_older, r_newer, i_sample};

endmodule

// ===== hdl/fdd_scale.sv =====
// ----------------------------------------------------------------------------
// fdd_scale
// Scales a signed numerator by an unsigned fixed-point reciprocal: magnitude,
// chunked multiply, round half away from zero, saturate, restore sign.
// ----------------------------------------------------------------------------
module fdd_scale #(
    parameter int SAMPLE_WIDTH = fdd_pkg::SAMPLE_WIDTH_DEF,
    parameter int FRAC_BITS    = fdd_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_adv,
    input  logic signed [SAMPLE_WIDTH+3:0]  i_num,
    input  logic [fdd_pkg::CFG_W-1:0]       i_recip,
    output logic [fdd_pkg::OUT_W-1:0]       o_result
);

    localparam int NW   = SAMPLE_WIDTH + 4;
    localparam int MW   = SAMPLE_WIDTH + 3;
    localparam int NCH  = (MW + 31) / 32;
    localparam int PADW = NCH * 32;
    localparam int RW   = PADW + 33;
    localparam logic [RW-1:0] HALF = (RW'(1) << FRAC_BITS) >> 1;

    // stage 2: sign and magnitude
    logic              r_neg2;
    logic [PADW-1:0]   r_mag2;
    // stage 3: partial products
    logic              r_neg3;
    logic [63:0]       r_pp3 [NCH];
    // stage 4: product plus rounding half
    logic              r_neg4;
    logic [RW-1:0]     r_sum4;
    // stage 5: result
    logic [fdd_pkg::OUT_W-1:0] r_res5;

    logic [NW-1:0]     abs_num;
    logic [RW-1:0]     n_sum;
    logic [RW-1:0]     shifted;
    logic [fdd_pkg::OUT_W-1:0] lim, q, n_res;
    logic              sat;

    assign abs_num = i_num[NW-1] ? (~i_num + 1'b1) : i_num;

    always_comb begin
        n_sum = HALF;
        for (int c = 0; c < NCH; c++) begin
            n_sum = n_sum + (RW'(r_pp3[c]) << (32 * c));
        end
    end

    always_comb begin
        shifted = r_sum4 >> FRAC_BITS;
        lim     = r_neg4 ? fdd_pkg::NEG_LIM : fdd_pkg::POS_LIM;
        sat     = (|shifted[RW-1:fdd_pkg::OUT_W]) || (shifted[fdd_pkg::OUT_W-1:0] > lim);
        q       = sat ? lim : shifted[fdd_pkg::OUT_W-1:0];
        n_res   = r_neg4 ? (~q + 1'b1) : q;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_neg2 <= i_num[NW-1];
            r_mag2 <= PADW'(abs_num[MW-1:0]);
            r_neg3 <= r_neg2;
            for (int c = 0; c < NCH; c++) begin
                r_pp3[c] <= 64'(r_mag2[32*c +: 32]) * 64'(i_recip);
            end
            r_neg4 <= r_neg3;
            r_sum4 <= n_sum;
            r_res5 <= n_res;
        end
    end

    assign o_result = r_res5;

endmodule

// ===== hdl/fdd_back.sv =====
// ----------------------------------------------------------------------------
// fdd_back
// Expands each queued entry into its one to three results, forms the
// numerators and drives two scaling lanes up to the output register.
// ----------------------------------------------------------------------------
module fdd_back #(
    parameter int SAMPLE_WIDTH = fdd_pkg::SAMPLE_WIDTH_DEF,
    parameter int FRAC_BITS    = fdd_pkg::FRAC_BITS_DEF,
    parameter int EW           = 3 * SAMPLE_WIDTH + fdd_pkg::FLAG_W
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fdd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fdd_pkg::CFG_W-1:0]       i_cfg_data,
    input  fdd_pkg::t_q_status              i_q_status,
    input  logic [EW-1:0]                   i_entry,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [fdd_pkg::OUT_W-1:0]       o_first_derivative,
    output logic [fdd_pkg::OUT_W-1:0]       o_second_derivative,
    output fdd_pkg::t_res_flags             o_flags
);

    localparam int NW = SAMPLE_WIDTH + 4;

    logic [fdd_pkg::CFG_W-1:0] r_inv_two, r_inv_sq;

    fdd_pkg::t_ent_flags       ef;
    logic signed [NW-1:0]      ea, eb, es;
    logic [1:0]                r_phase;
    fdd_pkg::t_kind            kind;
    logic                      entry_done, adv, issue;
    logic signed [NW-1:0]      num_d1, num_d2;
    fdd_pkg::t_res_flags       n_f1;

    logic signed [NW-1:0]      r_num1_d1, r_num1_d2;
    logic [4:0]                r_v;            // stages 1..5
    fdd_pkg::t_res_flags       r_f [5];

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_two <= fdd_pkg::INV_TWO_STEP_RST;
            r_inv_sq  <= fdd_pkg::INV_STEP_SQ_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fdd_pkg::REG_INV_TWO_STEP: r_inv_two <= i_cfg_data;
                fdd_pkg::REG_INV_STEP_SQ:  r_inv_sq  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign ef = i_entry[EW-1 -: fdd_pkg::FLAG_W];
    assign ea = NW'($signed(i_entry[3*SAMPLE_WIDTH-1 -: SAMPLE_WIDTH]));
    assign eb = NW'($signed(i_entry[2*SAMPLE_WIDTH-1 -: SAMPLE_WIDTH]));
    assign es = NW'($signed(i_entry[SAMPLE_WIDTH-1:0]));

    // whole back pipeline moves together; only the output beat can hold it
    assign adv   = !r_v[4] || !i_stall;
    assign issue = i_q_status.valid && adv;

    always_comb begin
        if (ef.shrt) begin
            kind = fdd_pkg::K_SHORT;
        end else if (ef.seen3) begin
            kind = (r_phase == 2'd0) ? fdd_pkg::K_MID : fdd_pkg::K_LAST;
        end else begin
            case (r_phase)
                2'd0:    kind = fdd_pkg::K_FIRST;
                2'd1:    kind = fdd_pkg::K_MID;
                default: kind = fdd_pkg::K_LAST;
            endcase
        end
    end

    always_comb begin
        num_d1     = '0;
        num_d2     = '0;
        n_f1       = '0;
        entry_done = 1'b0;
        unique case (kind)
            fdd_pkg::K_SHORT: begin
                n_f1.series_end   = 1'b1;
                n_f1.short_series = 1'b1;
                entry_done        = 1'b1;
            end
            fdd_pkg::K_FIRST: begin
                num_d1 = (eb <<< 2) - ((ea <<< 1) + ea) - es;
            end
            fdd_pkg::K_MID: begin
                num_d1          = es - ea;
                num_d2          = ea - (eb <<< 1) + es;
                n_f1.has_second = 1'b1;
                entry_done      = !ef.last;
            end
            fdd_pkg::K_LAST: begin
                num_d1          = ((es <<< 1) + es) - (eb <<< 2) + ea;
                n_f1.series_end = 1'b1;
                entry_done      = 1'b1;
            end
            default: ;
        endcase
        n_f1.last_of_run = entry_done;
    end

    assign o_pop = issue && entry_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_v     <= '0;
        end else if (adv) begin
            if (issue) begin
                r_phase <= entry_done ? 2'd0 : r_phase + 2'd1;
            end
            r_v <= {r_v[3:0], issue};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_num1_d1 <= num_d1;
            r_num1_d2 <= num_d2;
            r_f[0]    <= n_f1;
            for (int i = 1; i < 5; i++) begin
                r_f[i] <= r_f[i-1];
            end
        end
    end

    fdd_scale #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FRAC_BITS    (FRAC_BITS)
    ) u_scale_d1 (
        .i_clk    (i_clk),
        .i_adv    (adv),
        .i_num    (r_num1_d1),
        .i_recip  (r_inv_two),
        .o_result (o_first_derivative)
    );

    fdd_scale #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FRAC_BITS    (FRAC_BITS)
    ) u_scale_d2 (
        .i_clk    (i_clk),
        .i_adv    (adv),
        .i_num    (r_num1_d2),
        .i_recip  (r_inv_sq),
        .o_result (o_second_derivative)
    );

    assign o_valid = r_v[4];
    assign o_flags = r_f[4];

`ifndef SYNTHESIS
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != 2'd3)
        else $error("result phase out of range");
    a_phase_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_status.valid |-> r_phase == 2'd0)
        else $error("phase left open with no entry");
    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_flags.series_end |-> o_flags.last_of_run && !o_flags.has_second)
        else $error("series end beat not closing its run");
`endif

endmodule
